[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be true on a rising clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hw/rtl/itoa_pkg.sv]
// types, constants and the digit encoding for the integer to ascii converter
package itoa_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned RADIX_BITS     = 6;
  localparam int unsigned DIGIT_BITS     = 6;
  localparam int unsigned CHAR_BITS      = 7;
  localparam int unsigned M_TDATA_W      = ((CHAR_BITS + 7) / 8) * 8;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(36);

  localparam logic [DIGIT_BITS-1:0] DIGIT_DEC_MAX = DIGIT_BITS'(9);
  localparam logic [DIGIT_BITS-1:0] DIGIT_TEN     = DIGIT_BITS'(10);

  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = CHAR_BITS'(8'h2d);  // '-'
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = CHAR_BITS'(8'h30);  // '0'
  localparam logic [CHAR_BITS-1:0] CHAR_A_LOW = CHAR_BITS'(8'h61);  // 'a'
  localparam logic [CHAR_BITS-1:0] CHAR_NONE  = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_POP,
    ST_EMIT,
    ST_ERR
  } itoa_state_e;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } itoa_div_sts_t;

  // digit value 0..35 to '0'..'9', 'a'..'z'
  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    if (d > DIGIT_DEC_MAX) begin
      c = CHAR_A_LOW + CHAR_BITS'(d - DIGIT_TEN);
    end else begin
      c = CHAR_ZERO + CHAR_BITS'(d);
    end
    return c;
  endfunction

endpackage

[hw/rtl/integer_to_ascii_radix.sv]
// Converts a signed VALUE_BITS-bit integer to ASCII text in radix 2..36, one character
// per output request, most significant digit first, with a leading '-' for negative
// values and lower-case letters for digits above nine; the final character carries
// tlast. An out-of-range radix gives one character 0 with tlast and tuser (error) set.
// Each digit comes from the bit-serial divider (one quotient bit per cycle); digits
// are pushed onto a small stack memory and then popped, each character taking a
// registered memory read, then an output load. A new request is taken as soon as
// the last character sits in the output register.
`include "assert_macros.svh"

module integer_to_ascii_radix import itoa_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [((VALUE_BITS + RADIX_BITS + 7) / 8) * 8 - 1:0]
                               s_axis_tdata,   // value [VALUE_BITS-1:0], radix, zero pad
  // character side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // character [6:0], zero pad
  output logic                 m_axis_tlast,
  output logic                 m_axis_tuser    // error
);

  localparam int unsigned ADDR_W = $clog2(VALUE_BITS);
  localparam int unsigned SP_W   = $clog2(VALUE_BITS + 1);

  // sequencer state
  itoa_state_e state_q, state_d;
  logic [SP_W-1:0] sp_q, sp_d;          // digits currently on the stack
  logic neg_q, neg_d;                   // value was negative
  logic [RADIX_BITS-1:0] radix_q, radix_d;

  // input decode
  logic [VALUE_BITS-1:0] val_in;
  logic [VALUE_BITS-1:0] mag_in;
  logic [RADIX_BITS-1:0] radix_in;
  logic                  radix_ok;
  logic                  s_fire;

  assign val_in   = s_axis_tdata[VALUE_BITS-1:0];
  assign radix_in = s_axis_tdata[VALUE_BITS +: RADIX_BITS];
  // unsigned magnitude, so the most negative value converts exactly
  assign mag_in   = val_in[VALUE_BITS-1] ? (~val_in + VALUE_BITS'(1)) : val_in;
  assign s_fire   = s_axis_tvalid && s_axis_tready;

  // divider
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [RADIX_BITS-1:0] div_divisor;
  itoa_div_sts_t         div_sts;
  logic [VALUE_BITS-1:0] div_quo;
  logic [DIGIT_BITS-1:0] div_rem;

  // first division takes the fresh magnitude, later ones the previous quotient
  assign div_dividend = (state_q == ST_IDLE) ? mag_in : div_quo;
  assign div_divisor  = (state_q == ST_IDLE) ? radix_in : radix_q;

  itoa_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .sts_o       (div_sts),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // digit stack, least significant digit pushed first
  logic [DIGIT_BITS-1:0] stack_mem [VALUE_BITS];
  logic                  stack_we;
  logic                  stack_re;
  logic [ADDR_W-1:0]     stack_waddr;
  logic [ADDR_W-1:0]     stack_raddr;
  logic [DIGIT_BITS-1:0] stack_rd_q;
  logic [SP_W-1:0]       sp_dec;

  assign sp_dec      = sp_q - SP_W'(1);
  assign stack_waddr = sp_q[ADDR_W-1:0];
  assign stack_raddr = sp_dec[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= div_rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stack_re) begin
      stack_rd_q <= stack_mem[stack_raddr];
    end
  end

  // output register
  logic                 out_valid_q;
  logic [CHAR_BITS-1:0] out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;
  logic                 out_err_q, out_err_d;
  logic                 out_load;
  logic                 out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d       = state_q;
    sp_d          = sp_q;
    neg_d         = neg_q;
    radix_d       = radix_q;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    stack_we      = 1'b0;
    stack_re      = 1'b0;
    out_load      = 1'b0;
    out_char_d    = CHAR_NONE;
    out_last_d    = 1'b0;
    out_err_d     = 1'b0;
    radix_ok      = radix_in inside {[RADIX_MIN:RADIX_MAX]};

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = !div_sts.busy;
        if (s_fire) begin
          neg_d   = val_in[VALUE_BITS-1];
          radix_d = radix_in;
          sp_d    = '0;
          if (radix_ok) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            state_d = ST_ERR;
          end
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          stack_we = 1'b1;
          sp_d     = sp_q + SP_W'(1);
          if (div_quo == '0) begin
            state_d = ST_SIGN;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_SIGN: begin
        if (!neg_q) begin
          state_d = ST_POP;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_char_d = CHAR_MINUS;
          state_d    = ST_POP;
        end
      end
      ST_POP: begin
        // read the top digit; it lands in stack_rd_q next cycle
        stack_re = 1'b1;
        sp_d     = sp_dec;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_char_d = digit_char(stack_rd_q);
          out_last_d = (sp_q == '0);
          state_d    = (sp_q == '0) ? ST_IDLE : ST_POP;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_char_d = CHAR_NONE;
          out_last_d = 1'b1;
          out_err_d  = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sp_q    <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    radix_q <= radix_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
      out_err_q  <= out_err_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_char_q);
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_err_q;

  // an error result is a lone zero character that closes the conversion
  logic err_shape_ok;
  assign err_shape_ok = m_axis_tlast && (out_char_q == CHAR_NONE);

  `ASSERT_CLK(a_err_is_single, (m_axis_tvalid && m_axis_tuser) |-> err_shape_ok, "bad error result")
  `ASSERT_NEVER(a_ready_while_dividing, s_axis_tready && div_sts.busy, "request while dividing")
  `ASSERT_CLK(a_done_in_div, div_sts.done |-> (state_q == ST_DIV), "divider done outside collection")
  `ASSERT_NEVER(a_stack_overflow, sp_q > SP_W'(VALUE_BITS), "digit stack overflow")

endmodule

[hw/rtl/itoa_divider.sv]
// bit-serial restoring divider, one quotient bit per cycle
`include "assert_macros.svh"

module itoa_divider import itoa_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [RADIX_BITS-1:0] divisor_i,
  output itoa_div_sts_t         sts_o,
  output logic [VALUE_BITS-1:0] quotient_o,
  output logic [DIGIT_BITS-1:0] remainder_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [DIGIT_BITS-1:0] rem_q, rem_d;
  logic [RADIX_BITS-1:0] div_q, div_d;

  logic [DIGIT_BITS:0]   trial;
  logic                  fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[VALUE_BITS-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_BITS);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_BITS-2:0], fits};
      rem_d = fits ? DIGIT_BITS'(trial - {1'b0, div_q}) : DIGIT_BITS'(trial);
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign sts_o.busy  = busy_q;
  assign sts_o.done  = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  `ASSERT_CLK(a_done_after_busy, done_q |-> $past(busy_q), "divider done without a running division")
  `ASSERT_CLK(a_rem_below_div, done_q |-> (rem_q < div_q), "remainder not below divisor")

endmodule

[sim/tb_integer_to_ascii_radix.sv]
// self-checking stream testbench for the integer to ascii radix converter
module tb_integer_to_ascii_radix;

  timeunit 1ns;
  timeprecision 1ps;

  import itoa_pkg::*;

  // request word width as the block derives it for 32-bit values
  localparam int unsigned VBITS     = 32;
  localparam int unsigned S_TDATA_W = ((VBITS + RADIX_BITS + 7) / 8) * 8;
  // wait after the drain, long enough for an extra character to show up
  localparam int unsigned DRAIN_CYCLES = 1500;
  localparam int unsigned RANDOM_REQS  = 285;

  // one expected character on the output stream
  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 last;
    logic                 err;
  } char_rec_t;

  // how a directed row gets its expected text
  typedef enum logic [1:0] {
    EXP_TEXT,   // text typed into the row
    EXP_FAULT,  // radix out of range: one flagged character
    EXP_MODEL   // worked out by the predictor
  } exp_kind_e;

  typedef struct {
    logic [VBITS-1:0]      value;
    logic [RADIX_BITS-1:0] radix;
    exp_kind_e             kind;
    string                 text;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // value [31:0], radix [37:32], zero pad
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;       // character [6:0], zero pad
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;       // error

  // characters still owed by the block, oldest first
  char_rec_t pending_chars[$];

  int unsigned n_fail  = 0;
  int unsigned n_req   = 0;
  int unsigned n_chars = 0;
  int unsigned n_fault = 0;
  int unsigned n_minus = 0;

  // no-idle stretches, redrawn now and then by the stimulus
  bit calm_tx = 1'b0;
  bit calm_rx = 1'b0;

  integer_to_ascii_radix #(
    .VALUE_BITS(VBITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run (all radix 2 with full stalls is ~4 ms)
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // idle cycles before the next handshake on either side
  function automatic int unsigned pick_gap(input bit calm);
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // expected text of one conversion: optional sign, then digits msd first
  function automatic void spell_number(input logic [VBITS-1:0] value,
                                       input logic [RADIX_BITS-1:0] radix);
    logic [VBITS-1:0]      mag;
    logic [VBITS-1:0]      base;
    logic [DIGIT_BITS-1:0] digs[$];
    logic [DIGIT_BITS-1:0] d;
    logic [CHAR_BITS-1:0]  c;
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      pending_chars.push_back('{ch: CHAR_NONE, last: 1'b1, err: 1'b1});
      return;
    end
    base = VBITS'(radix);
    // unsigned negate, so the most negative value keeps its full magnitude
    mag = value[VBITS-1] ? (~value + 1'b1) : value;
    do begin
      digs.push_front(DIGIT_BITS'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (value[VBITS-1]) begin
      pending_chars.push_back('{ch: CHAR_MINUS, last: 1'b0, err: 1'b0});
    end
    for (int i = 0; i < digs.size(); i++) begin
      d = digs[i];
      // digits past nine map onto the lower-case letters
      c = (d > 9) ? CHAR_A_LOW + CHAR_BITS'(d) - CHAR_BITS'(10) : CHAR_ZERO + CHAR_BITS'(d);
      pending_chars.push_back('{ch: c, last: (i == digs.size() - 1), err: 1'b0});
    end
  endfunction

  // hand one request to the block; returns right after the accepting edge
  task automatic send_request(input logic [VBITS-1:0] value, input logic [RADIX_BITS-1:0] radix);
    int unsigned gap;
    gap = pick_gap(calm_tx);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - VBITS - RADIX_BITS){1'b0}}, radix, value};
    do @(posedge clk_i); while (!s_axis_tready);
    n_req++;
  endtask

  // character sink: random stall before each character, check on every handshake
  initial begin : char_sink
    int unsigned stall;
    char_rec_t   want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = pick_gap(calm_rx);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      n_chars++;
      if (m_axis_tuser === 1'b1) begin
        n_fault++;
      end
      if (pending_chars.size() == 0) begin
        $error("character 0x%02h with no request outstanding", m_axis_tdata[CHAR_BITS-1:0]);
        n_fail++;
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata[CHAR_BITS-1:0] !== want.ch) begin
          $error("character: expected 0x%02h, got 0x%02h", want.ch,
                 m_axis_tdata[CHAR_BITS-1:0]);
          n_fail++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          n_fail++;
        end
        if (m_axis_tuser !== want.err) begin
          $error("error: expected %0b, got %0b", want.err, m_axis_tuser);
          n_fail++;
        end
      end
    end
  end

  // stimulus: directed table first, then random requests
  initial begin : stimulus
    dir_row_t              rows[];
    logic [VBITS-1:0]      v;
    logic [RADIX_BITS-1:0] r;
    rows = '{
      // zero in the smallest, the usual and the largest radix
      '{32'd0,          6'd10, EXP_TEXT,  "0"},
      '{32'd0,          6'd2,  EXP_TEXT,  "0"},
      '{32'd0,          6'd36, EXP_TEXT,  "0"},
      '{32'd1,          6'd10, EXP_TEXT,  "1"},
      '{32'hffff_ffff,  6'd10, EXP_TEXT,  "-1"},
      '{32'hffff_ffff,  6'd36, EXP_TEXT,  "-1"},
      // most negative and most positive values
      '{32'h8000_0000,  6'd10, EXP_TEXT,  "-2147483648"},
      '{32'h7fff_ffff,  6'd10, EXP_TEXT,  "2147483647"},
      '{32'h8000_0000,  6'd16, EXP_TEXT,  "-80000000"},
      '{32'h7fff_ffff,  6'd16, EXP_TEXT,  "7fffffff"},
      '{32'h8000_0000,  6'd2,  EXP_MODEL, ""},
      '{32'h7fff_ffff,  6'd2,  EXP_MODEL, ""},
      '{32'h8000_0000,  6'd36, EXP_MODEL, ""},
      // digit to letter boundary
      '{32'd9,          6'd10, EXP_TEXT,  "9"},
      '{32'd10,         6'd11, EXP_TEXT,  "a"},
      '{32'd35,         6'd36, EXP_TEXT,  "z"},
      '{32'hffff_ffdd,  6'd36, EXP_TEXT,  "-z"},
      '{32'd36,         6'd36, EXP_TEXT,  "10"},
      '{32'd1295,       6'd36, EXP_TEXT,  "zz"},
      '{32'd255,        6'd2,  EXP_TEXT,  "11111111"},
      '{32'hdead_beef,  6'd7,  EXP_MODEL, ""},
      // radix out of range on both sides
      '{32'd123,        6'd0,  EXP_FAULT, ""},
      '{32'hffff_ffff,  6'd1,  EXP_FAULT, ""},
      '{32'hffff_fffb,  6'd37, EXP_FAULT, ""},
      '{32'h7fff_ffff,  6'd63, EXP_FAULT, ""}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_request(rows[i].value, rows[i].radix);
      if (rows[i].value[VBITS-1] && rows[i].kind != EXP_FAULT) begin
        n_minus++;
      end
      case (rows[i].kind)
        EXP_TEXT: begin
          for (int k = 0; k < rows[i].text.len(); k++) begin
            pending_chars.push_back('{ch: CHAR_BITS'(rows[i].text[k]),
                                      last: (k == rows[i].text.len() - 1), err: 1'b0});
          end
        end
        EXP_FAULT: begin
          pending_chars.push_back('{ch: CHAR_NONE, last: 1'b1, err: 1'b1});
        end
        default: begin
          spell_number(rows[i].value, rows[i].radix);
        end
      endcase
    end

    for (int n = 0; n < RANDOM_REQS; n++) begin
      // redraw the idle pattern so both busy and quiet stretches occur
      if (n % 40 == 0) begin
        calm_tx = ($urandom_range(0, 3) == 0);
        calm_rx = ($urandom_range(0, 3) == 0);
      end
      case ($urandom_range(0, 5))
        0: v = $urandom;
        1: v = $urandom >> $urandom_range(0, 31);
        2: v = -($urandom >> $urandom_range(0, 31));
        3: v = VBITS'($urandom_range(0, 80)) - VBITS'(40);
        4: v = $urandom >> $urandom_range(20, 31);
        default: begin
          case ($urandom_range(0, 3))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = 32'hffff_ffff;
            default: v = '0;
          endcase
        end
      endcase
      // mostly legal radices, the full 6-bit range now and then
      if ($urandom_range(0, 9) < 8) begin
        r = RADIX_BITS'($urandom_range(2, 36));
      end else begin
        r = RADIX_BITS'($urandom_range(0, 63));
      end
      send_request(v, r);
      if (v[VBITS-1] && r >= RADIX_MIN && r <= RADIX_MAX) begin
        n_minus++;
      end
      spell_number(v, r);
    end
    s_axis_tvalid <= 1'b0;

    // drain, then give a stray extra character time to show up
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d conversions (%0d negative, radices 0..63), %0d characters checked",
             n_req, n_minus, n_chars);
    $display("%0d out-of-range radix results, %0d mismatches", n_fault, n_fail);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
